### rtl/core/fbm_pkg.sv
// ---------------------------------------------------------------------------
// fbm_pkg
// shared types, constants and tables for the 4fsk byte modulator
// ---------------------------------------------------------------------------
package fbm_pkg;

    localparam int SYM_W      = 16;
    localparam int COEF_W     = 16;
    localparam int LEVEL_W    = 8;
    localparam int COEF_IDX_W = 9;
    localparam int SYMS_PER_BYTE = 4;

    localparam logic signed [SYM_W-1:0] SYM_HI = 16'sd1362;
    localparam logic signed [SYM_W-1:0] SYM_LO = 16'sd454;

    localparam logic [1:0] DIBIT_N_LO = 2'b00;
    localparam logic [1:0] DIBIT_N_HI = 2'b01;
    localparam logic [1:0] DIBIT_P_LO = 2'b10;
    localparam logic [1:0] DIBIT_P_HI = 2'b11;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd128;

    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

    function automatic logic signed [SYM_W-1:0] map_dibit(input logic [1:0] dibit);
        logic signed [SYM_W-1:0] v;
        unique case (dibit)
            DIBIT_P_HI: v = SYM_HI;
            DIBIT_P_LO: v = SYM_LO;
            DIBIT_N_LO: v = -SYM_LO;
            DIBIT_N_HI: v = -SYM_HI;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // gaussian pulse, 45 taps, zero outside the central lobe
    function automatic logic [COEF_W-1:0] pulse_coeff(input logic [COEF_IDX_W-1:0] idx);
        logic [COEF_W-1:0] c;
        unique case (idx)
            9'd16:   c = 16'd17;
            9'd17:   c = 16'd319;
            9'd18:   c = 16'd2659;
            9'd19:   c = 16'd10668;
            9'd20:   c = 16'd22736;
            9'd21:   c = 16'd30728;
            9'd22:   c = 16'd32767;
            9'd23:   c = 16'd30728;
            9'd24:   c = 16'd22736;
            9'd25:   c = 16'd10668;
            9'd26:   c = 16'd2659;
            9'd27:   c = 16'd319;
            9'd28:   c = 16'd17;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/fbm_stream_if.sv
// ---------------------------------------------------------------------------
// fbm stream interfaces
// valid/ready channels for input bytes and output samples
// ---------------------------------------------------------------------------
interface fbm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface fbm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

### rtl/core/fbm_mac.sv
// ---------------------------------------------------------------------------
// fbm_mac
// shared signed multiply-accumulate unit
// ---------------------------------------------------------------------------
module fbm_mac
    import fbm_pkg::*;
#(
    parameter int ACC_W = 38
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctl                       i_ctl,
    input  logic signed [SYM_W-1:0]        i_a,
    input  logic signed [COEF_W:0]         i_b,
    output logic signed [ACC_W-1:0]        o_acc
);

    logic signed [SYM_W+COEF_W:0] prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      n_acc;

    always_comb begin
        prod  = i_a * i_b;
        n_acc = (i_ctl.clr ? '0 : r_acc) + ACC_W'(prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/core/fourfsk_byte_modulator.sv
// ---------------------------------------------------------------------------
// fourfsk_byte_modulator
// 4fsk byte modulator with gaussian polyphase interpolating filter
// ---------------------------------------------------------------------------
// sequence: each byte passes per symbol through MAP, PUSH, then MAC and EMIT per
//   phase; a sample is registered when EMIT is left; a new byte is taken only in IDLE;
//   the rate is set by the single multiply-accumulate unit, plus output stalls
// reset: synchronous active low; history cleared, level 128, channels idle
// ---------------------------------------------------------------------------
module fourfsk_byte_modulator
    import fbm_pkg::*;
#(
    parameter int UPSAMPLE   = 5,
    parameter int PHASE_TAPS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_level_we,
    input  logic [LEVEL_W-1:0] i_level_wdata,
    fbm_in_if.sink             i_in,
    fbm_out_if.source          o_out
);

    localparam int ACC_W   = SYM_W + COEF_W + 1 + $clog2(PHASE_TAPS + 1);
    localparam int TAP_W   = $clog2(PHASE_TAPS);
    localparam int PH_W    = $clog2(UPSAMPLE);
    localparam int IDX_W   = $clog2(UPSAMPLE * PHASE_TAPS);
    localparam int SCNT_W  = $clog2(SYMS_PER_BYTE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_MAC  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic [2:0]               r_state, n_state;
    logic [LEVEL_W-1:0]       r_level;
    logic                     r_mode;
    logic [7:0]               r_byte, n_byte;
    logic [SCNT_W-1:0]        r_sym, n_sym;
    logic [PH_W-1:0]          r_phase, n_phase;
    logic [TAP_W-1:0]         r_tap, n_tap;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic signed [SYM_W-1:0]  r_hist [PHASE_TAPS];
    logic                     r_out_valid;
    logic signed [SYM_W-1:0]  r_sample;
    logic                     r_last;

    t_mac_ctl                 mac_ctl;
    logic signed [SYM_W-1:0]  mac_a;
    logic signed [COEF_W:0]   mac_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sh;
    logic signed [SYM_W-1:0]  acc_sat;
    logic                     in_beat;
    logic                     out_free;
    logic                     emit_load;
    logic                     push;
    logic                     emit_last;
    logic [TAP_W-1:0]         hist_sel;

    fbm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    assign in_beat   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign emit_load = (r_state == ST_EMIT) && out_free;
    assign push      = (r_state == ST_PUSH);
    assign emit_last = (r_sym == SCNT_W'(SYMS_PER_BYTE - 1))
                    && (r_phase == PH_W'(UPSAMPLE - 1));
    assign hist_sel  = TAP_W'(PHASE_TAPS - 1) - r_tap;

    // symbol gain needs >>8, filter output >>15
    always_comb begin
        acc_sh = push ? (acc >>> 8) : (acc >>> 15);
        if (acc_sh > SAT_MAX) begin
            acc_sat = 16'sh7fff;
        end else if (acc_sh < SAT_MIN) begin
            acc_sat = -16'sh8000;
        end else begin
            acc_sat = SYM_W'(acc_sh);
        end
    end

    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        if (r_state == ST_MAP) begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = 1'b1;
            mac_a       = r_mode ? '0 : map_dibit(r_byte[7:6]);
            mac_b       = (COEF_W + 1)'(r_level);
        end else if (r_state == ST_MAC) begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = (r_tap == '0);
            mac_a       = r_hist[hist_sel];
            mac_b       = $signed({1'b0, pulse_coeff(COEF_IDX_W'(r_idx))});
        end
    end

    always_comb begin
        n_state = r_state;
        n_byte  = r_byte;
        n_sym   = r_sym;
        n_phase = r_phase;
        n_tap   = r_tap;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_byte  = i_in.data_byte;
                    n_sym   = '0;
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                n_byte  = {r_byte[5:0], 2'b00};
                n_phase = '0;
                n_tap   = '0;
                n_idx   = IDX_W'(UPSAMPLE - 1);
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_idx = r_idx + IDX_W'(UPSAMPLE);
                if (r_tap == TAP_W'(PHASE_TAPS - 1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_phase != PH_W'(UPSAMPLE - 1)) begin
                        n_phase = r_phase + 1'b1;
                        n_tap   = '0;
                        n_idx   = IDX_W'(UPSAMPLE - 2) - IDX_W'(r_phase);
                        n_state = ST_MAC;
                    end else if (r_sym != SCNT_W'(SYMS_PER_BYTE - 1)) begin
                        n_sym   = r_sym + 1'b1;
                        n_state = ST_MAP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= LEVEL_RESET;
            r_out_valid <= 1'b0;
            r_sym       <= '0;
            r_phase     <= '0;
            r_tap       <= '0;
            r_idx       <= '0;
            for (int k = 0; k < PHASE_TAPS; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sym   <= n_sym;
            r_phase <= n_phase;
            r_tap   <= n_tap;
            r_idx   <= n_idx;
            if (i_level_we) begin
                r_level <= i_level_wdata;
            end
            if (push) begin
                r_hist[0] <= acc_sat;
                for (int k = 1; k < PHASE_TAPS; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (in_beat) begin
            r_mode <= i_in.mode;
        end
        if (emit_load) begin
            r_sample <= acc_sat;
            r_last   <= emit_last;
        end
    end

    assign i_in.ready   = (r_state == ST_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;
    assign o_out.last   = r_last;

    a_beat_starts_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == ST_MAP))
        else $error("input beat did not start symbol mapping");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && emit_last) |=> (r_state == ST_IDLE))
        else $error("final sample loaded but sequencer not idle");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_tap <= TAP_W'(PHASE_TAPS - 1)))
        else $error("tap counter out of range");

endmodule
